// File: sv/assert_macros.svh
// assertion helpers included by the core rtl file
// both expect signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// File: sv/stsc_pkg.sv
package stsc_pkg;

   localparam int ELEMENT_BITS = 32;
   localparam int MATCH_BITS   = 20;
   localparam int COUNT_BITS   = 11;
   localparam int EPOCH_BITS   = 8;

   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_SUM_BITS      = 48;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [MATCH_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

   // golden ratio multiplier, split into 32 bit halves
   localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
   localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_ISSUE,
      ST_HASH_WAIT,
      ST_LOOKUP,
      ST_RECORD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic lookup;
   } hash_ctl_type;

endpackage

// File: sv/stsc_req_if.sv
interface stsc_req_if import stsc_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [ELEMENT_BITS-1:0] element;
   logic                           last_element;

   modport source (output valid, element, last_element, input ready);
   modport sink (input valid, element, last_element, output ready);
endinterface

// File: sv/stsc_rsp_if.sv
interface stsc_rsp_if import stsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MATCH_BITS-1:0] match_count;
   logic                  found;
   logic                  table_full;
   logic                  last_result;

   modport source (output valid, match_count, found, table_full, last_result, input ready);
   modport sink (input valid, match_count, found, table_full, last_result, output ready);
endinterface

// File: sv/stsc_ram.sv
module stsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/stsc_hash.sv
// six stage slot hash: upper word of key * golden constant, reduced modulo the table size
module stsc_hash import stsc_pkg::*; #(
   parameter int SUM_BITS      = DEF_SUM_BITS,
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hash_ctl_type                     in_ctl,
   input  logic [SUM_BITS-1:0]              in_key,
   output hash_ctl_type                     out_ctl,
   output logic [$clog2(TABLE_ENTRIES)-1:0] out_idx
);

   localparam int          IDX_BITS = $clog2(TABLE_ENTRIES);
   localparam int          STAGES   = 6;
   localparam logic [31:0] MODULUS  = 32'(TABLE_ENTRIES);
   // floor(2^32 / n): quotient estimate is exact or one low
   localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / TABLE_ENTRIES);

   hash_ctl_type        ctl_ff [STAGES];
   logic [63:0]         key64;
   logic [63:0]         prod_a;
   logic [63:0]         prod_q;
   logic [31:0]         a_hi_ff;
   logic [31:0]         kh1_ff;
   logic [31:0]         kl1_ff;
   logic [31:0]         kl2_ff;
   logic [31:0]         b_ff;
   logic [31:0]         h_ff;
   logic [31:0]         h4_ff;
   logic [31:0]         q_ff;
   logic [31:0]         r_ff;
   logic [IDX_BITS-1:0] idx_ff;

   assign key64  = 64'(in_key);
   assign prod_a = 64'(key64[31:0]) * 64'(HASH_MUL_LO);
   assign prod_q = 64'(h_ff) * 64'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int i = 1; i < STAGES; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_hi_ff <= prod_a[63:32];
      kh1_ff  <= key64[63:32];
      kl1_ff  <= key64[31:0];
      // cross products only reach the upper word through their low halves
      b_ff    <= a_hi_ff + 32'(kh1_ff * HASH_MUL_LO);
      kl2_ff  <= kl1_ff;
      h_ff    <= b_ff + 32'(kl2_ff * HASH_MUL_HI);
      q_ff    <= prod_q[63:32];
      h4_ff   <= h_ff;
      r_ff    <= h4_ff - 32'(q_ff * MODULUS);
      idx_ff  <= (r_ff >= MODULUS) ? IDX_BITS'(r_ff - MODULUS) : IDX_BITS'(r_ff);
   end

   assign out_ctl = ctl_ff[STAGES-1];
   assign out_idx = idx_ff;

endmodule

// File: sv/subarray_target_sum_count_core.sv
// Counts subarrays whose sum equals the target, one array after another.
// req_port carries one signed element per item plus a last-element flag;
// rsp_port returns one item per element: running match count, found flag,
// table-full flag and a copy of the last flag. csr_wr_en/csr_wr_data load the
// target sum; write it only while the block is idle.
// Prefix counts live in a hashed table in one synchronous RAM with linear
// probing. Table slots are probed in turn (lookup of prefix minus target,
// then insert of the prefix); both keys go through the six-stage hash unit,
// and the single RAM read port serves each probe. One item is worked
// on at a time; a new item is accepted while the previous result still waits
// in the output register, but the block holds in its final state until the
// receiver has taken that result.
// Reset (synchronous) clears the target and the array state and then sweeps
// every table slot with req_port.ready low. Entries carry an array tag, so
// ending an array is immediate, except every 255th array, which triggers the
// same sweep.
module subarray_target_sum_count_core import stsc_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int SUM_BITS      = DEF_SUM_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   stsc_req_if.sink                       req_port,
   stsc_rsp_if.source                     rsp_port,
   input  logic                           csr_wr_en,
   input  logic signed [ELEMENT_BITS-1:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam int                 IDX_BITS  = $clog2(TABLE_ENTRIES);
   localparam int                 WORD_BITS = EPOCH_BITS + SUM_BITS + COUNT_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

   state_type                      state_ff, state_in;
   logic signed [ELEMENT_BITS-1:0] tgt_ff;
   logic [SUM_BITS-1:0]            sum_ff, sum_in;
   logic [SUM_BITS-1:0]            diff_ff, diff_in;
   logic                           last_ff, last_in;
   logic [COUNT_BITS-1:0]          zero_cnt_ff, zero_cnt_in;
   logic [MATCH_BITS-1:0]          total_ff, total_in;
   logic                           ovf_ff, ovf_in;
   logic [EPOCH_BITS-1:0]          epoch_ff, epoch_in;
   logic [IDX_BITS-1:0]            idx_ff, idx_in;
   logic [IDX_BITS-1:0]            probe_ff, probe_in;
   logic [IDX_BITS-1:0]            rec_idx_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [MATCH_BITS-1:0]          rsp_match_ff;
   logic                           rsp_found_ff;
   logic                           rsp_full_ff;
   logic                           rsp_last_ff;

   logic                           ram_wr_en;
   logic [WORD_BITS-1:0]           ram_wr_data;
   logic [WORD_BITS-1:0]           ram_rd_data;
   hash_ctl_type                   hash_in_ctl;
   logic [SUM_BITS-1:0]            hash_in_key;
   hash_ctl_type                   hash_out_ctl;
   logic [IDX_BITS-1:0]            hash_out_idx;

   logic [EPOCH_BITS-1:0]          ent_epoch;
   logic [SUM_BITS-1:0]            ent_key;
   logic [COUNT_BITS-1:0]          ent_count;
   logic                           ent_valid;
   logic [SUM_BITS-1:0]            probe_key;
   logic                           key_hit;
   logic                           probe_last;
   logic                           probe_end;
   logic [IDX_BITS-1:0]            idx_next;
   logic                           diff_zero;
   logic                           sum_zero;
   logic                           rsp_free;
   logic                           lookup_end;
   logic                           add_en;
   logic [COUNT_BITS-1:0]          hits;
   logic [MATCH_BITS:0]            total_sum;

   stsc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   stsc_hash #(
      .SUM_BITS      (SUM_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (hash_in_ctl),
      .in_key  (hash_in_key),
      .out_ctl (hash_out_ctl),
      .out_idx (hash_out_idx)
   );

   // table word: {array tag, key, count}; read data always belongs to idx_ff
   assign ent_epoch  = ram_rd_data[WORD_BITS-1 -: EPOCH_BITS];
   assign ent_key    = ram_rd_data[COUNT_BITS +: SUM_BITS];
   assign ent_count  = ram_rd_data[COUNT_BITS-1:0];
   assign ent_valid  = (ent_epoch == epoch_ff);
   assign probe_key  = (state_ff == ST_LOOKUP) ? diff_ff : sum_ff;
   assign key_hit    = ent_valid && (ent_key == probe_key);
   assign probe_last = (probe_ff == LAST_IDX);
   assign probe_end  = !ent_valid || key_hit || probe_last;
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign diff_zero  = (diff_ff == '0);
   assign sum_zero   = (sum_ff == '0);
   assign rsp_free   = !rsp_valid_ff || rsp_port.ready;
   assign lookup_end = ((state_ff == ST_HASH_WAIT) && hash_out_ctl.valid
                        && hash_out_ctl.lookup && diff_zero)
                       || ((state_ff == ST_LOOKUP) && probe_end);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_port.valid) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_HASH_WAIT;
         end
         ST_HASH_WAIT: begin
            if (hash_out_ctl.valid && hash_out_ctl.lookup) begin
               if (!diff_zero) begin
                  state_in = ST_LOOKUP;
               end else if (sum_zero) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RECORD;
               end
            end
         end
         ST_LOOKUP: begin
            if (probe_end) begin
               state_in = sum_zero ? ST_DONE : ST_RECORD;
            end
         end
         ST_RECORD: begin
            if (probe_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = (last_ff && (epoch_ff == EPOCH_MAX)) ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs to the handshake, the table and the hash unit
   always_comb begin
      req_port.ready = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_data    = '0;
      hash_in_ctl    = '0;
      hash_in_key    = sum_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_port.ready = 1'b1;
         end
         ST_DIFF: begin
            hash_in_ctl.valid = 1'b1;
         end
         ST_ISSUE: begin
            hash_in_ctl.valid  = 1'b1;
            hash_in_ctl.lookup = 1'b1;
            hash_in_key        = diff_ff;
         end
         ST_RECORD: begin
            if (!ent_valid) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {epoch_ff, sum_ff, COUNT_BITS'(1)};
            end else if (key_hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {epoch_ff, sum_ff,
                              (ent_count == COUNT_MAX) ? COUNT_MAX : ent_count + 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      last_in      = last_ff;
      zero_cnt_in  = zero_cnt_ff;
      ovf_in       = ovf_ff;
      epoch_in     = epoch_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      add_en       = 1'b0;
      hits         = ent_count;

      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_next;
            if (idx_ff == LAST_IDX) begin
               epoch_in = EPOCH_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (req_port.valid) begin
               sum_in  = sum_ff + SUM_BITS'(req_port.element);
               last_in = req_port.last_element;
            end
         end
         ST_DIFF: begin
            diff_in = sum_ff - SUM_BITS'(tgt_ff);
         end
         ST_HASH_WAIT: begin
            if (hash_out_ctl.valid && hash_out_ctl.lookup) begin
               probe_in = '0;
               if (!diff_zero) begin
                  idx_in = hash_out_idx;
               end else begin
                  // empty prefix is kept outside the table
                  add_en = 1'b1;
                  hits   = zero_cnt_ff;
                  idx_in = rec_idx_ff;
               end
            end
         end
         ST_LOOKUP: begin
            if (probe_end) begin
               add_en   = key_hit;
               idx_in   = rec_idx_ff;
               probe_in = '0;
            end else begin
               idx_in   = idx_next;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_RECORD: begin
            if (probe_end) begin
               if (!ent_valid || !key_hit) begin
                  ovf_in = ovf_ff || (ent_valid && !key_hit);
               end
            end else begin
               idx_in   = idx_next;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (last_ff) begin
                  sum_in      = '0;
                  zero_cnt_in = COUNT_BITS'(1);
                  ovf_in      = 1'b0;
                  if (epoch_ff == EPOCH_MAX) begin
                     epoch_in = '0;
                     idx_in   = '0;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (lookup_end && sum_zero && (zero_cnt_ff != COUNT_MAX)) begin
         zero_cnt_in = zero_cnt_ff + 1'b1;
      end

      total_sum = {1'b0, total_ff} + (MATCH_BITS + 1)'(hits);
      total_in  = total_ff;
      if (add_en) begin
         total_in = total_sum[MATCH_BITS] ? TOTAL_MAX : total_sum[MATCH_BITS-1:0];
      end
      if ((state_ff == ST_DONE) && rsp_free && last_ff) begin
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tgt_ff       <= '0;
         sum_ff       <= '0;
         last_ff      <= 1'b0;
         zero_cnt_ff  <= COUNT_BITS'(1);
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         epoch_ff     <= '0;
         idx_ff       <= '0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            tgt_ff <= csr_wr_data;
         end
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         zero_cnt_ff  <= zero_cnt_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         epoch_ff     <= epoch_in;
         idx_ff       <= idx_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      // insert slot comes out of the hash in the cycle before the lookup slot
      if (hash_out_ctl.valid && !hash_out_ctl.lookup) begin
         rec_idx_ff <= hash_out_idx;
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_match_ff <= total_ff;
         rsp_found_ff <= (total_ff != '0);
         rsp_full_ff  <= ovf_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.match_count = rsp_match_ff;
   assign rsp_port.found       = rsp_found_ff;
   assign rsp_port.table_full  = rsp_full_ff;
   assign rsp_port.last_result = rsp_last_ff;

   `ASSERT_CLK(a_array_cleared,
      ((state_ff == ST_DONE) && rsp_free && last_ff) |=>
      ((sum_ff == '0) && (zero_cnt_ff == COUNT_BITS'(1)) && (total_ff == '0) && !ovf_ff),
      "array state not cleared after last item")
   `ASSERT_NEVER(a_probe_tag_live,
      ((state_ff == ST_LOOKUP) || (state_ff == ST_RECORD)) && (epoch_ff == '0),
      "table probed with the cleared array tag")
   `ASSERT_NEVER(a_hash_unexpected,
      hash_out_ctl.valid && (state_ff != ST_HASH_WAIT),
      "hash result arrived outside the wait state")
   `ASSERT_NEVER(a_found_consistent,
      rsp_valid_ff && (rsp_found_ff != (rsp_match_ff != '0)),
      "found flag disagrees with match count")

endmodule

// File: tb/subarray_target_sum_count_core_tb.sv
module subarray_target_sum_count_core_tb;
   import stsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_W         = DEF_SUM_BITS;
   localparam int SLOTS         = DEF_TABLE_ENTRIES;
   localparam int STALL_STRETCH = 400;
   localparam int SETTLE_CYCLES = 50;

   typedef logic signed [ELEMENT_BITS-1:0] element_type;
   typedef logic [SUM_W-1:0] prefix_type;

   typedef struct {
      element_type element;
      logic        last;
   } element_item_type;

   typedef struct packed {
      logic [MATCH_BITS-1:0] match_count;
      logic                  found;
      logic                  table_full;
      logic                  last_result;
   } tally_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   element_type csr_wr_data = '0;

   stsc_req_if req_if ();
   stsc_rsp_if rsp_if ();

   subarray_target_sum_count_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // stimulus side
   element_item_type elements_to_send[$];
   tally_type        prefix_tallies[$];
   element_type      target_setting = '0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   bit               req_fire = 1'b0;
   bit               hold_req = 1'b0;
   bit               hold_ack = 1'b0;
   int               hold_left = 0;

   // predictor state
   element_type           target_now;
   prefix_type            prefix_now;
   logic [COUNT_BITS-1:0] empty_prefix_hits;
   logic [MATCH_BITS-1:0] matches_so_far;
   bit                    table_overflowed;
   bit                    slot_used [SLOTS];
   prefix_type            slot_prefix [SLOTS];
   logic [COUNT_BITS-1:0] slot_hits [SLOTS];

   // bookkeeping
   int mismatches = 0;
   int results_checked = 0;
   int arrays_checked = 0;
   int full_results = 0;
   int peak_count = 0;

   function automatic prefix_type sign_widen(element_type v);
      return {{(SUM_W-ELEMENT_BITS){v[ELEMENT_BITS-1]}}, v};
   endfunction

   function automatic int slot_of(prefix_type key);
      logic [63:0] product;
      product = 64'(key) * {HASH_MUL_HI, HASH_MUL_LO};
      return int'(product[63:32] % SLOTS);
   endfunction

   function automatic void wipe_array_state();
      prefix_now = '0;
      empty_prefix_hits = COUNT_BITS'(1);
      matches_so_far = '0;
      table_overflowed = 1'b0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
   endfunction

   function automatic tally_type advance_prefix_tally(element_type element, logic last);
      prefix_type want;
      int         idx;
      int         hits;
      int         total;
      bit         placed;
      tally_type  res;
      prefix_now = prefix_now + sign_widen(element);
      want = prefix_now - sign_widen(target_now);
      hits = 0;
      if (want == '0) begin
         hits = int'(empty_prefix_hits);
      end else begin
         idx = slot_of(want);
         for (int n = 0; n < SLOTS && slot_used[idx]; n++) begin
            if (slot_prefix[idx] == want) begin
               hits = int'(slot_hits[idx]);
               break;
            end
            idx = (idx + 1) % SLOTS;
         end
      end
      total = int'(matches_so_far) + hits;
      matches_so_far = (total > int'(TOTAL_MAX)) ? TOTAL_MAX : MATCH_BITS'(total);

      // the empty prefix lives in its own counter, the table only holds nonzero prefixes
      if (prefix_now == '0) begin
         if (empty_prefix_hits != COUNT_MAX) empty_prefix_hits = empty_prefix_hits + 1'b1;
      end else begin
         placed = 1'b0;
         idx = slot_of(prefix_now);
         for (int n = 0; n < SLOTS && !placed; n++) begin
            if (!slot_used[idx]) begin
               slot_used[idx] = 1'b1;
               slot_prefix[idx] = prefix_now;
               slot_hits[idx] = COUNT_BITS'(1);
               placed = 1'b1;
            end else if (slot_prefix[idx] == prefix_now) begin
               if (slot_hits[idx] != COUNT_MAX) slot_hits[idx] = slot_hits[idx] + 1'b1;
               placed = 1'b1;
            end else begin
               idx = (idx + 1) % SLOTS;
            end
         end
         if (!placed) table_overflowed = 1'b1;
      end

      res.match_count = matches_so_far;
      res.found       = (matches_so_far != '0);
      res.table_full  = table_overflowed;
      res.last_result = last;
      if (last) wipe_array_state();
      return res;
   endfunction

   // predictor and result checker
   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         target_now = '0;
         wipe_array_state();
         prefix_tallies.delete();
         req_fire = 1'b0;
      end else begin
         if (csr_wr_en) target_now = csr_wr_data;
         req_fire = req_if.valid && req_if.ready;
         if (req_fire)
            prefix_tallies.push_back(advance_prefix_tally(req_if.element, req_if.last_element));
         if (rsp_if.valid && rsp_if.ready) begin
            if (prefix_tallies.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with nothing expected: count=%0d", $realtime,
                           rsp_if.match_count);
               mismatches++;
            end else begin
               want = prefix_tallies.pop_front();
               if (rsp_if.match_count !== want.match_count || rsp_if.found !== want.found ||
                   rsp_if.table_full !== want.table_full ||
                   rsp_if.last_result !== want.last_result) begin
                  if (mismatches < 10) begin
                     $display("%0t: mismatch: expected count=%0d found=%0b full=%0b last=%0b",
                              $realtime, want.match_count, want.found, want.table_full,
                              want.last_result);
                     $display("%0t:           got count=%0d found=%0b full=%0b last=%0b",
                              $realtime, rsp_if.match_count, rsp_if.found,
                              rsp_if.table_full, rsp_if.last_result);
                  end
                  mismatches++;
               end
               results_checked++;
               if (want.last_result) arrays_checked++;
               if (want.table_full) full_results++;
               if (int'(want.match_count) > peak_count) peak_count = int'(want.match_count);
            end
         end
      end
   end

   // element driver
   always @(negedge clock) begin
      element_item_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (elements_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            item = elements_to_send.pop_front();
            req_if.valid <= 1'b1;
            req_if.element <= item.element;
            req_if.last_element <= item.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here so the driver keeps offering items
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_left <= STALL_STRETCH;
         hold_ack <= hold_req;
      end
   end

   always @(negedge clock)
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);

   task automatic offer(element_type element, logic last);
      element_item_type item;
      item.element = element;
      item.last = last;
      elements_to_send.push_back(item);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (elements_to_send.size() != 0 || req_if.valid || prefix_tallies.size() != 0);
   endtask

   task automatic load_target(element_type value);
      drain();
      // ready stays low while the table is being swept
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      target_setting = value;
   endtask

   function automatic element_type pick_element();
      int r;
      r = $urandom_range(99);
      if (r < 50) return element_type'($urandom_range(6)) - 3;
      if (r < 62) return target_setting;
      if (r < 70) return -target_setting;
      if (r < 80) begin
         case ($urandom_range(3))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            default: return '1;
         endcase
      end
      return element_type'($urandom);
   endfunction

   task automatic queue_random_arrays(int n_items);
      int made;
      int len;
      int r;
      made = 0;
      while (made < n_items) begin
         r = $urandom_range(99);
         len = (r < 60) ? $urandom_range(2, 1) :
               (r < 90) ? $urandom_range(10, 3) : $urandom_range(32, 11);
         for (int i = 0; i < len; i++) offer(pick_element(), i == len - 1);
         made += len;
      end
   endtask

   initial begin
      element_type random_targets [6];
      req_if.valid = 1'b0;
      req_if.element = '0;
      req_if.last_element = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed arrays, first idling mix
      req_idle_pct = 15;
      rsp_idle_pct = 84;
      load_target('0);
      offer('0, 1'b1);
      offer(32'sh7FFFFFFF, 1'b0);
      offer(32'sh80000000, 1'b0);
      offer(1, 1'b0);
      offer(-1, 1'b0);
      offer(1, 1'b1);
      repeat (2) offer(32'sh80000000, 1'b0);
      offer(32'sh80000000, 1'b1);
      offer(3, 1'b0);
      offer(-3, 1'b0);
      offer(3, 1'b0);
      offer(-3, 1'b0);
      offer('0, 1'b1);
      load_target(32'sh7FFFFFFF);
      offer(32'sh7FFFFFFF, 1'b1);
      offer(-1, 1'b0);
      offer(32'sh7FFFFFFF, 1'b0);
      offer(1, 1'b1);
      load_target(32'sh80000000);
      offer(32'sh80000000, 1'b1);
      offer(32'sh80000000, 1'b0);
      offer('0, 1'b0);
      offer(32'sh80000000, 1'b0);
      offer(32'sh7FFFFFFF, 1'b1);

      // random arrays under the three idling mixes
      random_targets[0] = '0;
      random_targets[1] = element_type'($urandom_range(10)) - 5;
      random_targets[2] = 32'sh7FFFFFFF;
      random_targets[3] = 32'sh80000000;
      random_targets[4] = element_type'($urandom);
      random_targets[5] = 2;
      for (int p = 0; p < 6; p++) begin
         load_target(random_targets[p]);
         if (p == 2) begin
            req_idle_pct = 84;
            rsp_idle_pct = 15;
         end else if (p == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_req = !hold_req;
         end
         queue_random_arrays(36);
      end

      // more distinct prefixes than slots: the tail of this array cannot be stored
      load_target('0);
      for (int i = 0; i < SLOTS + 6; i++) offer(1, 1'b0);
      offer(-6, 1'b0);
      offer(3, 1'b0);
      offer('0, 1'b1);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += prefix_tallies.size();

      $display("checked %0d results over %0d arrays, %0d with the table full, peak count %0d",
               results_checked, arrays_checked, full_results, peak_count);
      $display("targets covered both extremes, zero and random values");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: subarray_target_sum_count_core.f
+incdir+sv
sv/stsc_pkg.sv
sv/stsc_req_if.sv
sv/stsc_rsp_if.sv
sv/stsc_ram.sv
sv/stsc_hash.sv
sv/subarray_target_sum_count_core.sv
tb/subarray_target_sum_count_core_tb.sv
